FILE: hw/rtl/mac_prefix_match_table_top_assert.svh
// ----------------------------------------------------------------------------
// mac prefix match table assertion macros
// concurrent checks on clk_i, held off while rst_ni is low
// ----------------------------------------------------------------------------
`ifndef MAC_PREFIX_MATCH_TABLE_TOP_ASSERT_SVH
`define MAC_PREFIX_MATCH_TABLE_TOP_ASSERT_SVH

`ifndef SYNTHESIS
`define MPMT_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`define MPMT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define MPMT_ASSERT_IMPL(lbl, ante, cons, msg)
`define MPMT_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

FILE: hw/rtl/mpmt_pkg.sv
// ----------------------------------------------------------------------------
// mpmt_pkg
// shared types, codes and helpers of the mac prefix match table
// ----------------------------------------------------------------------------
`default_nettype none

package mpmt_pkg;

  localparam int unsigned AddrW = 48;
  localparam int unsigned LenW  = 6;
  localparam int unsigned StatW = 3;

  localparam logic [LenW-1:0]  MaxLen   = 6'd48;
  localparam logic [AddrW-1:0] AddrOnes = {AddrW{1'b1}};

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_QUERY  = 2'd1,
    ACT_CLEAR  = 2'd2
  } action_e;

  typedef enum logic [StatW-1:0] {
    ST_STORED  = 3'd0,
    ST_DUP     = 3'd1,
    ST_FULL    = 3'd2,
    ST_QUERY   = 3'd3,
    ST_CLEARED = 3'd4
  } status_e;

  // one beat travelling down the cell row
  typedef struct packed {
    logic             vld;
    action_e          act;
    logic [AddrW-1:0] addr;
    logic [LenW-1:0]  len;
    logic             hit;
    logic             stored;
  } probe_t;

  // top len bits set, len at most 48
  function automatic logic [AddrW-1:0] top_mask(input logic [LenW-1:0] len);
    top_mask = ~(AddrOnes >> len);
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/mpmt_if.sv
// ----------------------------------------------------------------------------
// mpmt channel interfaces
// request and response channels with valid/ready handshake
// ----------------------------------------------------------------------------
`default_nettype none

interface mpmt_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [47:0] mac_address;
  logic [5:0]  prefix_len;

  modport source (output valid, output action, output mac_address, output prefix_len,
                  input ready);
  modport sink   (input valid, input action, input mac_address, input prefix_len,
                  output ready);
endinterface

interface mpmt_rsp_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic       matched;

  modport source (output valid, output status, output matched, input ready);
  modport sink   (input valid, input status, input matched, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/mac_prefix_match_table_top.sv
// ----------------------------------------------------------------------------
// mac_prefix_match_table_top
// mac prefix rule table built as a row of rule cells that beats walk through
//
//   channel  dir  fields                              role
//   req_i    in   action, mac_address, prefix_len     insert / query / clear
//   rsp_o    out  status, matched                     one beat per action
//
// a beat moves one cell per cycle while the row advances; its answer is valid
// once it reaches the last cell, so the delay is set by the length of the cell row
// the row takes a new beat every cycle; it stalls as a whole while the
// response beat in the last cell waits for rsp_o.ready
// an action code of 3 is taken and produces no response beat
// reset empties the table at once (cell valid flags), no clearing pass
// ----------------------------------------------------------------------------
`default_nettype none

`include "mac_prefix_match_table_top_assert.svh"

module mac_prefix_match_table_top #(
  parameter int unsigned TABLE_DEPTH = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  mpmt_req_if.sink   req_i,
  mpmt_rsp_if.source rsp_o
);

  mpmt_pkg::probe_t           head_probe;
  mpmt_pkg::probe_t           probe [TABLE_DEPTH];
  mpmt_pkg::probe_t           tail;
  logic                       adv;
  logic [mpmt_pkg::LenW-1:0]  len_sat;
  logic                       act_ok;

  assign tail = probe[TABLE_DEPTH-1];
  assign adv  = !tail.vld || rsp_o.ready;
  assign req_i.ready = adv;

  assign act_ok  = (req_i.action == mpmt_pkg::ACT_INSERT) ||
                   (req_i.action == mpmt_pkg::ACT_QUERY) ||
                   (req_i.action == mpmt_pkg::ACT_CLEAR);
  assign len_sat = (req_i.prefix_len > mpmt_pkg::MaxLen) ? mpmt_pkg::MaxLen
                                                         : req_i.prefix_len;

  always_comb begin
    head_probe        = '0;
    head_probe.vld    = req_i.valid && act_ok;
    head_probe.act    = mpmt_pkg::action_e'(req_i.action);
    head_probe.len    = len_sat;
    head_probe.addr   = req_i.mac_address;
    if (req_i.action == mpmt_pkg::ACT_INSERT) begin
      head_probe.addr = req_i.mac_address & mpmt_pkg::top_mask(len_sat);
    end
  end

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_first
      mpmt_cell u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .adv_i   (adv),
        .probe_i (head_probe),
        .probe_o (probe[i])
      );
    end else begin : g_next
      mpmt_cell u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .adv_i   (adv),
        .probe_i (probe[i-1]),
        .probe_o (probe[i])
      );
    end
  end

  always_comb begin
    rsp_o.valid   = tail.vld;
    rsp_o.matched = 1'b0;
    rsp_o.status  = mpmt_pkg::ST_FULL;
    unique case (tail.act)
      mpmt_pkg::ACT_INSERT: begin
        if (tail.hit) begin
          rsp_o.status = mpmt_pkg::ST_DUP;
        end else if (tail.stored) begin
          rsp_o.status = mpmt_pkg::ST_STORED;
        end else begin
          rsp_o.status = mpmt_pkg::ST_FULL;
        end
      end
      mpmt_pkg::ACT_QUERY: begin
        rsp_o.status  = mpmt_pkg::ST_QUERY;
        rsp_o.matched = tail.hit;
      end
      mpmt_pkg::ACT_CLEAR: begin
        rsp_o.status = mpmt_pkg::ST_CLEARED;
      end
      default: begin
        rsp_o.status = mpmt_pkg::ST_FULL;
      end
    endcase
  end

  `MPMT_ASSERT_IMPL(a_ins_one_outcome, tail.vld, !(tail.hit && tail.stored), "insert both dup and stored")
  `MPMT_ASSERT_IMPL(a_match_query_only, rsp_o.valid && (rsp_o.status != mpmt_pkg::ST_QUERY), !rsp_o.matched, "matched set on non-query beat")
  `MPMT_ASSERT_NEXT(a_beat_enters_row, req_i.valid && req_i.ready && act_ok, probe[0].vld, "accepted beat missing in first cell")

endmodule

`default_nettype wire

FILE: hw/rtl/mpmt_cell.sv
// ----------------------------------------------------------------------------
// mpmt_cell
// one rule slot: compares, stores or clears as a beat passes, then forwards it
// ----------------------------------------------------------------------------
`default_nettype none

module mpmt_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            adv_i,
  input  mpmt_pkg::probe_t probe_i,
  output mpmt_pkg::probe_t probe_o
);

  logic [mpmt_pkg::AddrW-1:0] key_q, key_d;
  logic [mpmt_pkg::LenW-1:0]  len_q, len_d;
  logic                       valid_q, valid_d;
  mpmt_pkg::probe_t           probe_q, probe_d;
  logic                       ins_match;
  logic                       qry_match;

  assign ins_match = valid_q && (len_q == probe_i.len) && (key_q == probe_i.addr);
  assign qry_match = valid_q &&
                     ((probe_i.addr & mpmt_pkg::top_mask(len_q)) == key_q);

  always_comb begin
    key_d   = key_q;
    len_d   = len_q;
    valid_d = valid_q;
    probe_d = probe_i;
    if (probe_i.vld) begin
      unique case (probe_i.act)
        mpmt_pkg::ACT_INSERT: begin
          if (!probe_i.hit && !probe_i.stored) begin
            if (ins_match) begin
              probe_d.hit = 1'b1;
            end else if (!valid_q) begin
              // first free slot, all used slots already checked
              key_d          = probe_i.addr;
              len_d          = probe_i.len;
              valid_d        = 1'b1;
              probe_d.stored = 1'b1;
            end
          end
        end
        mpmt_pkg::ACT_QUERY: begin
          if (qry_match) begin
            probe_d.hit = 1'b1;
          end
        end
        mpmt_pkg::ACT_CLEAR: begin
          valid_d = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      probe_q <= '0;
    end else if (adv_i) begin
      valid_q <= valid_d;
      probe_q <= probe_d;
    end
  end

  // rule storage, no reset
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      key_q <= key_d;
      len_q <= len_d;
    end
  end

  assign probe_o = probe_q;

endmodule

`default_nettype wire
